### src/crr_pkg.sv
// Shared types and constants for the chained range remap unit.
// No dependencies; imported by crr_table and chained_range_remap_unit.
package crr_pkg;

    localparam int STAGES  = 7;
    localparam int WINDOWS = 32;
    localparam int ENTRIES = STAGES * WINDOWS;

    localparam int DATA_W  = 32;
    localparam int STAGE_FIELD_W = 3;
    localparam int SLOT_FIELD_W  = 5;
    localparam int HIT_W   = 7;

    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int SLOT_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;

    localparam logic [1:0] REQ_LOAD      = 2'd0;
    localparam logic [1:0] REQ_TRANSLATE = 2'd1;
    localparam logic [1:0] REQ_CLEAR     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] dest;
        logic [DATA_W-1:0] len;
    } window_t;

    typedef struct packed {
        logic              we;
        logic              clr;
        logic [ADDR_W-1:0] addr;
        window_t           entry;
    } tbl_wr_t;

endpackage

### src/crr_table.sv
// Window table: one memory of windows for all stages, plus a valid bit per entry.
// Single write port, single registered read port. Depends on crr_pkg.
module crr_table (
    input  logic                    clk,
    input  logic                    rst_n,
    input  crr_pkg::tbl_wr_t        wr,
    input  logic [crr_pkg::ADDR_W-1:0] rd_addr,
    output crr_pkg::window_t        rd_entry,
    output logic                    rd_valid
);
    import crr_pkg::*;

    window_t            mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    window_t            rd_entry_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // clear drops every mark at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.clr)
            begin
                valid_reg <= '0;
            end
            else if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### src/chained_range_remap_unit.sv
// Top level of the chained range remap unit: sequencer, shared compare/offset unit.
// Depends on crr_pkg and crr_table.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  request  | start, busy        | req_type, stage_index, slot_index,
//           |                    | dest_start, src_start, window_length, value_in
//  result   | done (1-cycle)     | value_out, hit_mask
//
// Load and clear items take effect in the accept cycle; busy stays low.
// A translate item keeps busy high while the single table read port scans one window per
// cycle, then passes one drain and one apply state per stage.
// done is raised as busy falls, so the next item can be accepted in that cycle.
// Reset clears all valid marks at once; no clearing pass. The receiver cannot stall.
module chained_range_remap_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         req_type,
    input  logic [crr_pkg::STAGE_FIELD_W-1:0]  stage_index,
    input  logic [crr_pkg::SLOT_FIELD_W-1:0]   slot_index,
    input  logic [crr_pkg::DATA_W-1:0]         dest_start,
    input  logic [crr_pkg::DATA_W-1:0]         src_start,
    input  logic [crr_pkg::DATA_W-1:0]         window_length,
    input  logic [crr_pkg::DATA_W-1:0]         value_in,
    output logic                               done,
    output logic [crr_pkg::DATA_W-1:0]         value_out,
    output logic [crr_pkg::HIT_W-1:0]          hit_mask
);
    import crr_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [STAGE_W-1:0]  stage_reg, stage_next;
    logic                cmp_en_reg, cmp_en_next;
    logic                found_reg, found_next;
    logic                done_reg, done_next;

    logic [DATA_W-1:0]   v_reg, v_next;
    logic [HIT_W-1:0]    mask_reg, mask_next;
    logic [DATA_W-1:0]   best_src_reg, best_src_next;
    logic [DATA_W-1:0]   best_dest_reg, best_dest_next;
    logic [DATA_W-1:0]   best_len_reg, best_len_next;
    logic [DATA_W-1:0]   best_off_reg, best_off_next;
    logic [DATA_W-1:0]   value_out_reg, value_out_next;
    logic [HIT_W-1:0]    hit_mask_reg, hit_mask_next;

    tbl_wr_t             tbl_wr;
    window_t             rd_entry;
    logic                rd_valid;

    logic                accept;
    logic                load_ok;
    logic                cand;
    logic                stage_hit;
    logic [DATA_W-1:0]   v_apply;
    logic [HIT_W-1:0]    mask_apply;

    crr_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_addr  (addr_reg),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    assign accept  = start && !busy;
    assign load_ok = (32'(stage_index) < 32'(STAGES)) && (32'(slot_index) < 32'(WINDOWS));

    // largest start not above the value; strict > keeps the lowest slot on ties
    assign cand = cmp_en_reg && rd_valid && (rd_entry.src <= v_reg)
                  && (!found_reg || (rd_entry.src > best_src_reg));

    assign stage_hit = found_reg && (best_off_reg < best_len_reg);
    assign v_apply   = stage_hit ? (best_dest_reg + best_off_reg) : v_reg;

    always_comb
    begin
        mask_apply = mask_reg;
        for (int i = 0; i < HIT_W; i++)
        begin
            if (stage_hit && (32'(stage_reg) == i))
            begin
                mask_apply[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        slot_next      = slot_reg;
        stage_next     = stage_reg;
        cmp_en_next    = (state_reg == ST_SCAN);
        found_next     = found_reg;
        done_next      = 1'b0;
        v_next         = v_reg;
        mask_next      = mask_reg;
        best_src_next  = best_src_reg;
        best_dest_next = best_dest_reg;
        best_len_next  = best_len_reg;
        best_off_next  = best_off_reg;
        value_out_next = value_out_reg;
        hit_mask_next  = hit_mask_reg;

        tbl_wr            = '0;
        tbl_wr.addr       = ADDR_W'(32'(stage_index) * 32'(WINDOWS) + 32'(slot_index));
        tbl_wr.entry.src  = src_start;
        tbl_wr.entry.dest = dest_start;
        tbl_wr.entry.len  = window_length;

        if (cand)
        begin
            found_next     = 1'b1;
            best_src_next  = rd_entry.src;
            best_dest_next = rd_entry.dest;
            best_len_next  = rd_entry.len;
            best_off_next  = v_reg - rd_entry.src;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_LOAD:
                        begin
                            tbl_wr.we = load_ok;
                        end
                        REQ_CLEAR:
                        begin
                            tbl_wr.clr = 1'b1;
                        end
                        REQ_TRANSLATE:
                        begin
                            v_next     = value_in;
                            mask_next  = '0;
                            addr_next  = '0;
                            slot_next  = '0;
                            stage_next = '0;
                            found_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_W'(WINDOWS - 1))
                begin
                    slot_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                v_next     = v_apply;
                mask_next  = mask_apply;
                found_next = 1'b0;
                if (stage_reg == STAGE_W'(STAGES - 1))
                begin
                    done_next      = 1'b1;
                    value_out_next = v_apply;
                    hit_mask_next  = mask_apply;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            addr_reg   <= '0;
            slot_reg   <= '0;
            stage_reg  <= '0;
            cmp_en_reg <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            slot_reg   <= slot_next;
            stage_reg  <= stage_next;
            cmp_en_reg <= cmp_en_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        mask_reg      <= mask_next;
        best_src_reg  <= best_src_next;
        best_dest_reg <= best_dest_next;
        best_len_reg  <= best_len_next;
        best_off_reg  <= best_off_next;
        value_out_reg <= value_out_next;
        hit_mask_reg  <= hit_mask_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign hit_mask  = hit_mask_reg;

    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_APPLY))
        else $error("result strobe without a final apply cycle");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_translate_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_TRANSLATE)) |=> busy)
        else $error("translate item accepted without going busy");

    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((32'(hit_mask) >> STAGES) == 32'd0))
        else $error("hit bit set for a stage that does not exist");

endmodule
